// ===== design/ordered_list_engine_assert.svh =====
// Assertion macros shared by the ordered list engine checkers.
// Each macro expects clk in its scope, all but the last also rst_n.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define OLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define OLE_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ole_pkg.sv =====
// Shared types and codes for the ordered list engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_BADPOS = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_DATA   = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] item_value;
    logic [5:0]         position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [2:0]         status;
    logic               last;
    logic [5:0]         length;
  } out_t;

endpackage
`default_nettype wire

// ===== design/ole_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/ordered_list_engine.sv =====
// Ordered list engine on ole_pkg and ole_ram: circular buffer in one RAM, head and count in flops.
// Insert, append, full/bad/empty, end deletes: result next cycle, 1 per cycle if out_stall is low.
// Middle delete: one RAM shift per moved entry in S_DEL, then the result is registered.
// Dump: one entry per cycle off the registered RAM read, while out_stall is low.
// One transaction in flight; the next is accepted at the edge that takes its last result.
// Reset (synchronous, rst_n low) empties the list; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire ole_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ole_pkg::out_t     out_data
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int SW   = CNTW + 1;
  localparam int CMPW = (CNTW > 6) ? CNTW : 6;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [IW-1:0]   head_r, head_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] idx_r, idx_nxt;
  logic [CNTW-1:0] widx_r, widx_nxt;
  logic            dv_r, dv_nxt;
  logic            wv_r, wv_nxt;
  logic            out_valid_r, out_valid_nxt;
  ole_pkg::out_t   out_r, out_nxt;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  logic [31:0]     wdata, rdata;
  logic            out_free, accept, full, take;
  logic [CNTW-1:0] rd_idx;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                         input logic [CNTW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(k);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return IW'(s);
  endfunction

  function automatic ole_pkg::out_t mk(input logic [31:0] v, input logic [2:0] st,
                                       input logic lst, input logic [CNTW-1:0] n);
    ole_pkg::out_t r;
    r.out_value = v;
    r.status    = st;
    r.last      = lst;
    r.length    = 6'(n);
    return r;
  endfunction

  ole_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign full      = count_r >= CNTW'(CAPACITY);
  assign take      = dv_r && out_free;
  assign rd_idx    = take ? idx_r + CNTW'(1) : idx_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    widx_nxt      = widx_r;
    dv_nxt        = dv_r;
    wv_nxt        = wv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = phys(head_r, count_r);
    wdata         = in_data.item_value;
    raddr         = phys(head_r, idx_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (in_data.operation) inside
            ole_pkg::OP_INSERT, ole_pkg::OP_APPEND: begin
              if (full) begin
                out_nxt = mk('0, ole_pkg::ST_FULL, 1'b1, count_r);
              end else begin
                we        = 1'b1;
                count_nxt = count_r + CNTW'(1);
                if (in_data.operation == ole_pkg::OP_INSERT) begin
                  head_nxt = (head_r == '0) ? IW'(CAPACITY - 1) : head_r - IW'(1);
                  waddr    = head_nxt;
                end
                out_nxt = mk('0, ole_pkg::ST_DONE, 1'b1, count_nxt);
              end
            end
            ole_pkg::OP_DELETE: begin
              if (in_data.position == '0 ||
                  CMPW'(in_data.position) > CMPW'(count_r)) begin
                out_nxt = mk('0, ole_pkg::ST_BADPOS, 1'b1, count_r);
              end else if (CMPW'(in_data.position) == CMPW'(count_r) ||
                           in_data.position == 6'd1) begin
                if (in_data.position == 6'd1) begin
                  head_nxt = phys(head_r, CNTW'(1));
                end
                count_nxt = count_r - CNTW'(1);
                out_nxt   = mk('0, ole_pkg::ST_DONE, 1'b1, count_nxt);
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_DEL;
                idx_nxt       = CNTW'(in_data.position);
                wv_nxt        = 1'b0;
              end
            end
            default: begin
              if (count_r == '0) begin
                out_nxt = mk('0, ole_pkg::ST_EMPTY, 1'b1, count_r);
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_DUMP;
                idx_nxt       = '0;
                dv_nxt        = 1'b0;
              end
            end
          endcase
        end
      end
      S_DEL: begin
        // read entry idx, write last cycle's data one place toward the front
        if (wv_r) begin
          we    = 1'b1;
          waddr = phys(head_r, widx_r);
          wdata = rdata;
        end
        if (idx_r < count_r) begin
          wv_nxt   = 1'b1;
          widx_nxt = idx_r - CNTW'(1);
          idx_nxt  = idx_r + CNTW'(1);
        end else begin
          wv_nxt        = 1'b0;
          count_nxt     = count_r - CNTW'(1);
          out_valid_nxt = 1'b1;
          out_nxt       = mk('0, ole_pkg::ST_DONE, 1'b1, count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      S_DUMP: begin
        raddr   = phys(head_r, rd_idx);
        dv_nxt  = 1'b1;
        idx_nxt = rd_idx;
        if (take) begin
          out_valid_nxt = 1'b1;
          out_nxt = mk(rdata, ole_pkg::ST_DATA, rd_idx == count_r, count_r);
          if (rd_idx == count_r) begin
            dv_nxt    = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      widx_r      <= '0;
      dv_r        <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      widx_r      <= widx_nxt;
      dv_r        <= dv_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== design/ole_checker.sv =====
// Port-level checker for ordered_list_engine, bound into every instance.
// Depends on ole_pkg and ordered_list_engine_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_engine_assert.svh"
module ole_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire ole_pkg::out_t out_data
);

  logic in_accept;
  logic out_hold;
  logic status_res;

  assign in_accept  = in_valid && !in_stall;
  assign out_hold   = out_valid && out_stall;
  assign status_res = out_valid && out_data.status != ole_pkg::ST_DATA;

  `OLE_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_data), "held transaction changed")
  `OLE_ASSERT_SAME(a_status_last, status_res, out_data.last, "status result without last")
  `OLE_ASSERT_SAME(a_status_zero, status_res, out_data.out_value == '0, "nonzero status value")
  `OLE_ASSERT_ALWAYS_NEXT(a_reset_idle, !rst_n, !out_valid, "result valid after reset")
  `OLE_ASSERT_NEXT(a_one_at_a_time, in_accept, in_stall || out_valid, "input taken before result")

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
`default_nettype wire

// ===== verif/tb_ordered_list_engine.sv =====
// Self-checking testbench for ordered_list_engine: random and directed list operations.
// Depends on ole_pkg and the ordered_list_engine RTL; runs on its own with no inputs.
`timescale 1ns / 1ps
module tb_ordered_list_engine;

  localparam int LIST_DEPTH = ole_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_HOLD = 400;

  class list_scoreboard;
    logic signed [31:0] values[$];
    ole_pkg::out_t expected_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int held();
      return values.size();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_expected(logic signed [31:0] v, logic [2:0] st, logic lst);
      ole_pkg::out_t e;
      e.out_value = v;
      e.status = st;
      e.last = lst;
      e.length = 6'(values.size());
      expected_q.push_back(e);
    endfunction

    function void note_input(ole_pkg::in_t item);
      case (item.operation) inside
        ole_pkg::OP_INSERT, ole_pkg::OP_APPEND: begin
          if (values.size() >= LIST_DEPTH) begin
            push_expected('0, ole_pkg::ST_FULL, 1'b1);
          end else begin
            if (item.operation == ole_pkg::OP_INSERT) values.push_front(item.item_value);
            else values.push_back(item.item_value);
            push_expected('0, ole_pkg::ST_DONE, 1'b1);
          end
        end
        ole_pkg::OP_DELETE: begin
          if (item.position == 0 || item.position > values.size()) begin
            push_expected('0, ole_pkg::ST_BADPOS, 1'b1);
          end else begin
            values.delete(item.position - 1);
            push_expected('0, ole_pkg::ST_DONE, 1'b1);
          end
        end
        default: begin
          if (values.size() == 0) begin
            push_expected('0, ole_pkg::ST_EMPTY, 1'b1);
          end else begin
            foreach (values[k])
              push_expected(values[k], ole_pkg::ST_DATA, k == values.size() - 1);
          end
        end
      endcase
    endfunction

    function void check_result(ole_pkg::out_t got);
      ole_pkg::out_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value=%0d status=%0d last=%0d length=%0d",
                   got.out_value, got.status, got.last, got.length);
        return;
      end
      e = expected_q.pop_front();
      if (got.out_value !== e.out_value || got.status !== e.status ||
          got.last !== e.last || got.length !== e.length) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp value=%0d status=%0d last=%0d length=%0d, ",
                   e.out_value, e.status, e.last, e.length,
                   "got value=%0d status=%0d last=%0d length=%0d",
                   got.out_value, got.status, got.last, got.length);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ole_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  ole_pkg::out_t out_data;

  list_scoreboard sb;
  int cycle_count;
  bit quiet_in;
  bit quiet_out;
  bit hold_req;

  ordered_list_engine #(.CAPACITY(LIST_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ordered_list_engine: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stall bursts, quiet stretches and one long hold
  initial begin
    int stall_left;
    int run_left;
    out_stall = 1'b0;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
        run_left = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (run_left > 0 || quiet_out) begin
        out_stall <= 1'b0;
        if (run_left > 0) run_left--;
      end else begin
        out_stall <= 1'b0;
        run_left = $urandom_range(0, 20);
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic signed [31:0] v,
                           input logic [5:0] pos);
    ole_pkg::in_t item;
    int gap;
    gap = quiet_in ? 0 : pick_gap();
    item.operation = op;
    item.item_value = v;
    item.position = pos;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sb.note_input(item);
  endtask

  task automatic run_episode(input int n, input int w_ins, input int w_app,
                             input int w_del);
    int r;
    logic [5:0] pos;
    repeat (n) begin
      r = $urandom_range(0, 99);
      pos = 6'($urandom_range(0, 63));
      if (r < w_ins) begin
        send_item(ole_pkg::OP_INSERT, pick_value(), pos);
      end else if (r < w_ins + w_app) begin
        send_item(ole_pkg::OP_APPEND, pick_value(), pos);
      end else if (r < w_ins + w_app + w_del) begin
        if (sb.held() > 0 && $urandom_range(0, 99) < 80)
          pos = 6'($urandom_range(1, sb.held()));
        send_item(ole_pkg::OP_DELETE, pick_value(), pos);
      end else begin
        send_item(ole_pkg::OP_DUMP, pick_value(), pos);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, extremes, ends and middle of the list
    send_item(ole_pkg::OP_DUMP, 32'sd0, 6'd0);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd0);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd1);
    send_item(ole_pkg::OP_INSERT, 32'sh7fffffff, 6'd63);
    send_item(ole_pkg::OP_APPEND, 32'sh80000000, 6'd0);
    send_item(ole_pkg::OP_INSERT, -32'sd1, 6'd0);
    send_item(ole_pkg::OP_APPEND, 32'sd0, 6'd32);
    send_item(ole_pkg::OP_DUMP, -32'sd1, 6'd63);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd0);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd63);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd5);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd2);
    send_item(ole_pkg::OP_DUMP, 32'sd0, 6'd0);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd3);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd1);
    send_item(ole_pkg::OP_DUMP, 32'sd0, 6'd0);
    send_item(ole_pkg::OP_DELETE, 32'sd0, 6'd1);
    send_item(ole_pkg::OP_DUMP, 32'sd0, 6'd0);
    send_item(ole_pkg::OP_APPEND, 32'sh55555555, 6'd21);
    send_item(ole_pkg::OP_INSERT, 32'shaaaaaaaa, 6'd42);
    send_item(ole_pkg::OP_DUMP, 32'sd0, 6'd0);

    // grow toward a full list, first stretch with no idling
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    run_episode(20, 45, 45, 5);
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    run_episode(25, 45, 45, 5);
    while (sb.held() < LIST_DEPTH)
      send_item(ole_pkg::OP_APPEND, pick_value(), 6'($urandom_range(0, 63)));
    send_item(ole_pkg::OP_INSERT, pick_value(), 6'($urandom_range(0, 63)));
    send_item(ole_pkg::OP_APPEND, pick_value(), 6'($urandom_range(0, 63)));
    send_item(ole_pkg::OP_DUMP, pick_value(), 6'($urandom_range(0, 63)));

    wait_drained();
    run_episode(30, 5, 5, 80);

    hold_req = 1'b1;
    run_episode(45, 30, 30, 25);
    send_item(ole_pkg::OP_DUMP, pick_value(), 6'($urandom_range(0, 63)));

    wait_drained();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** ordered_list_engine: PASSED **");
    end else begin
      $display("** ordered_list_engine: FAILED **");
    end
    $finish;
  end
endmodule

// ===== ordered_list_engine.f =====
+incdir+design
design/ole_pkg.sv
design/ole_ram.sv
design/ordered_list_engine.sv
design/ole_checker.sv
verif/tb_ordered_list_engine.sv
